FILE: src/ptfl_pkg.sv
// ----------------------------------------------------------------------------
// ptfl_pkg: shared types and constants of the page translation block
// Holds the controller state codes, the command and status bundles between
// the controller and the datapath, and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ptfl_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int ADDR_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register map.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY        = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST   = 5'd12;
    localparam logic [CFG_DATA_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    // Legal range of the offset width.
    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_MIN = 5'd1;
    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_MAX = 5'd20;

    // Replacement policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LFU  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } ptfl_state_t;

    typedef struct packed {
        logic load;     // capture the input item and restart the scan
        logic scan;     // read the next frame entry
        logic update;   // commit the decision and load the result
    } ptfl_cmd_t;

    typedef struct packed {
        logic scan_last; // the entry being read is the last managed frame
        logic out_free;  // the result register can take a new item
    } ptfl_sts_t;

endpackage

`default_nettype wire

FILE: src/ptfl_ram.sv
// ----------------------------------------------------------------------------
// ptfl_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: src/ptfl_ctrl.sv
// ----------------------------------------------------------------------------
// ptfl_ctrl: sequencer of the page translation block
// Accepts an item, walks the frame table once, waits for the last read,
// then commits the update when the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ptfl_ctrl import ptfl_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire ptfl_sts_t sts,
    output ptfl_cmd_t      cmd
);

    ptfl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last entry read is still on its way out of the RAM.
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A scan never runs past the last managed frame.
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && sts.scan_last) |=> !cmd.scan)
        else $error("scan continued after the last frame");

endmodule

`default_nettype wire

FILE: src/ptfl_dp.sv
// ----------------------------------------------------------------------------
// ptfl_dp: datapath of the page translation block
// Configuration registers, the frame table RAM with its occupied bits, the
// scan trackers for hit, free frame and victims, the totals and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptfl_dp import ptfl_pkg::*; #(
    parameter int NUM_FRAMES = 16,
    parameter int ADDR_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic [ADDR_W-1:0]     in_addr,
    input  wire logic                  in_write,
    input  wire logic                  m_tready,
    input  wire ptfl_cmd_t             cmd,
    output ptfl_sts_t                  sts,
    output logic                       m_valid,
    output logic [ADDR_W-1:0]          out_phys,
    output logic                       out_hit,
    output logic                       out_dirty,
    output logic [TOTAL_W-1:0]         out_faults,
    output logic [TOTAL_W-1:0]         out_swaps
);

    localparam int IDX_W   = $clog2(NUM_FRAMES);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int NW      = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int PAGE_W  = ADDR_BITS - 1;
    localparam int ENTRY_W = 1 + COUNT_BITS + PAGE_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                            : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration.
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] frames_reg;
    logic                  policy_reg;
    logic [CFG_DATA_W-1:0] ob_eff;
    logic [NW-1:0]         frames_ext;
    logic [CNT_W-1:0]      n_eff;

    // Current item.
    logic [ADDR_W-1:0] addr_reg;
    logic              wr_reg;
    logic [PAGE_W-1:0] page_reg;

    // Scan.
    logic [IDX_W-1:0]      idx_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      pidx_reg;
    logic [NUM_FRAMES-1:0] occ_reg;
    logic [ENTRY_W-1:0]    rdata;
    logic [PAGE_W-1:0]     rd_page;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  rd_dirty;
    logic                  rd_occ;

    // Trackers.
    logic                  found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic                  hit_dirty_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [IDX_W-1:0]      min_idx_reg;
    logic [COUNT_BITS-1:0] min_cnt_reg;
    logic                  min_dirty_reg;
    logic                  fifo_dirty_reg;
    logic [IDX_W-1:0]      fifo_ptr_reg;
    logic [IDX_W-1:0]      fifo_sel;

    // Decision.
    logic [IDX_W-1:0]      frame;
    logic                  victim_dirty;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  new_dirty;
    logic [ENTRY_W-1:0]    wdata;
    logic [ADDR_W-1:0]     off_mask;
    logic [TOTAL_W-1:0]    fault_reg;
    logic [TOTAL_W-1:0]    swap_reg;
    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     phys_reg;
    logic                  hit_out_reg;
    logic                  dirty_out_reg;

    // Effective configuration with out-of-range values clamped.
    always_comb begin
        if (offset_bits_reg < OFFSET_BITS_MIN) begin
            ob_eff = OFFSET_BITS_MIN;
        end else if (offset_bits_reg > OFFSET_BITS_MAX) begin
            ob_eff = OFFSET_BITS_MAX;
        end else begin
            ob_eff = offset_bits_reg;
        end
        frames_ext = NW'(frames_reg);
        if (frames_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (frames_ext > NW'(NUM_FRAMES)) begin
            n_eff = CNT_W'(NUM_FRAMES);
        end else begin
            n_eff = CNT_W'(frames_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            frames_reg      <= FRAMES_IN_USE_RST;
            policy_reg      <= POLICY_FIFO;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OFFSET_BITS:   offset_bits_reg <= cfg_wr_data;
                REG_FRAMES_IN_USE: frames_reg      <= cfg_wr_data;
                REG_POLICY:        policy_reg      <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Frame table: dirty mark, use count and resident page of each frame.
    ptfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (frame),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign rd_page  = rdata[PAGE_W-1:0];
    assign rd_cnt   = rdata[PAGE_W +: COUNT_BITS];
    assign rd_dirty = rdata[ENTRY_W-1];
    assign rd_occ   = occ_reg[pidx_reg];

    assign fifo_sel = (CNT_W'(fifo_ptr_reg) < n_eff) ? fifo_ptr_reg : '0;

    assign sts.scan_last = (CNT_W'(idx_reg) == n_eff - CNT_W'(1));
    assign sts.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= in_addr & ADDR_MASK;
            wr_reg   <= in_write;
            page_reg <= PAGE_W'((64'(in_addr & ADDR_MASK)) >> ob_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.scan;
            pidx_reg <= idx_reg;
            if (cmd.load) begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (pend_reg && rd_occ && !found_reg && rd_page == page_reg) begin
                    found_reg <= 1'b1;
                end
                if (pend_reg && !rd_occ && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Trackers fed by the entry read in the previous cycle.
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            if (rd_occ && !found_reg && rd_page == page_reg) begin
                hit_idx_reg   <= pidx_reg;
                hit_cnt_reg   <= rd_cnt;
                hit_dirty_reg <= rd_dirty;
            end
            if (!rd_occ && !free_found_reg) begin
                free_idx_reg <= pidx_reg;
            end
            // Strict compare keeps the lowest index on ties.
            if (pidx_reg == '0 || rd_cnt < min_cnt_reg) begin
                min_idx_reg   <= pidx_reg;
                min_cnt_reg   <= rd_cnt;
                min_dirty_reg <= rd_dirty;
            end
            if (pidx_reg == fifo_sel) begin
                fifo_dirty_reg <= rd_dirty;
            end
        end
    end

    always_comb begin
        if (found_reg) begin
            frame = hit_idx_reg;
        end else if (free_found_reg) begin
            frame = free_idx_reg;
        end else if (policy_reg == POLICY_LFU) begin
            frame = min_idx_reg;
        end else begin
            frame = fifo_sel;
        end
        victim_dirty = !found_reg && !free_found_reg
                     && ((policy_reg == POLICY_LFU) ? min_dirty_reg : fifo_dirty_reg);
        if (found_reg) begin
            new_cnt   = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                                   : hit_cnt_reg + COUNT_BITS'(1);
            new_dirty = hit_dirty_reg | wr_reg;
        end else begin
            new_cnt   = COUNT_BITS'(1);
            new_dirty = wr_reg;
        end
        wdata    = {new_dirty, new_cnt, page_reg};
        off_mask = (ADDR_W'(1) << ob_eff) - ADDR_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            fifo_ptr_reg <= '0;
            fault_reg    <= '0;
            swap_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.update) begin
                occ_reg[frame] <= 1'b1;
                m_valid_reg    <= 1'b1;
                if (!found_reg) begin
                    fault_reg <= fault_reg + TOTAL_W'(1);
                end
                if (victim_dirty) begin
                    swap_reg <= swap_reg + TOTAL_W'(1);
                end
                if (!found_reg && !free_found_reg && policy_reg == POLICY_FIFO) begin
                    fifo_ptr_reg <= (CNT_W'(frame) + CNT_W'(1) == n_eff) ? '0
                                                                        : frame + IDX_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            phys_reg      <= (ADDR_W'(frame) << ob_eff) | (addr_reg & off_mask);
            hit_out_reg   <= found_reg;
            dirty_out_reg <= victim_dirty;
        end
    end

    // Totals only move on a commit, which waits for the previous result to go.
    assign m_valid    = m_valid_reg;
    assign out_phys   = phys_reg;
    assign out_hit    = hit_out_reg;
    assign out_dirty  = dirty_out_reg;
    assign out_faults = fault_reg;
    assign out_swaps  = swap_reg;

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid_reg)
        else $error("commit did not load the result register");

    a_totals_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.update |=> ($stable(fault_reg) && $stable(swap_reg) && $stable(occ_reg)))
        else $error("totals or occupied bits changed without a commit");

    a_hit_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && found_reg) |=> ($stable(fault_reg) && $stable(swap_reg)))
        else $error("a hit changed the fault or swap-out total");

endmodule

`default_nettype wire

FILE: src/page_translate_fifo_lfu_top.sv
// ----------------------------------------------------------------------------
// page_translate_fifo_lfu_top: address translation with FIFO or LFU paging
// Inverted page table over the managed frames: hit lookup, free frame fill
// and victim replacement with dirty swap-out counting.
//
//   Group   Direction  tdata (low bit up)                       tuser
//   s_      in         logical_address[31:0]                   write_flag
//   m_      out        physical_address, fault_total,          hit, dirty_evicted
//                      swap_out_total (32 bits each)
//   cfg_    in         write enable, register index, data      -
//
// An item is accepted, then the frame table RAM is read one entry a cycle for
// each of the n frames in use, the last read is awaited and the update is
// committed. The single RAM read port sets that rate of reading.
// Reset is synchronous and needs no clearing pass; every frame starts free.
// The result register holds a finished item while the next one is scanned;
// a commit waits only while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module page_translate_fifo_lfu_top import ptfl_pkg::*; #(
    parameter int NUM_FRAMES = 16,
    parameter int ADDR_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // logical_address
    input  wire logic [0:0]            s_tuser,   // write_flag
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [95:0]                m_tdata,   // physical_address, fault_total,
                                                  // swap_out_total
    output logic [1:0]                 m_tuser    // hit, dirty_evicted
);

    ptfl_cmd_t          cmd;
    ptfl_sts_t          sts;
    logic [ADDR_W-1:0]  out_phys;
    logic               out_hit;
    logic               out_dirty;
    logic [TOTAL_W-1:0] out_faults;
    logic [TOTAL_W-1:0] out_swaps;

    ptfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptfl_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_addr     (s_tdata),
        .in_write    (s_tuser[0]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_tvalid),
        .out_phys    (out_phys),
        .out_hit     (out_hit),
        .out_dirty   (out_dirty),
        .out_faults  (out_faults),
        .out_swaps   (out_swaps)
    );

    assign m_tdata = {out_swaps, out_faults, out_phys};
    assign m_tuser = {out_dirty, out_hit};

endmodule

`default_nettype wire

FILE: verif/tb_page_translate_fifo_lfu_top.sv
// ----------------------------------------------------------------------------
// tb_page_translate_fifo_lfu_top: self-checking bench of the paging block
// Streams memory references through the translator, predicts every result
// with an in-bench copy of the inverted page table and checks each result
// item field by field. The run covers both replacement policies, clamped
// register values, a frame count lowered and raised again, and source and
// sink stalls.
// ----------------------------------------------------------------------------

module tb_page_translate_fifo_lfu_top import ptfl_pkg::*;;

    localparam int FRAMES     = 16;
    localparam int DRAIN_WAIT = 40;
    localparam int LONG_HOLD  = 300;

    typedef struct {
        logic [31:0] addr;
        logic        wr;
    } access_t;

    typedef struct packed {
        logic [31:0] phys_addr;
        logic        hit;
        logic        dirty_evicted;
        logic [31:0] fault_total;
        logic [31:0] swap_out_total;
    } xlat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_OFFSET_BITS;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;     // logical_address
    logic [0:0]            s_tuser = '0;     // write_flag
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [95:0]           m_tdata;          // physical_address, fault_total,
                                             // swap_out_total
    logic [1:0]            m_tuser;          // hit, dirty_evicted

    page_translate_fifo_lfu_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Shadow of the configuration registers and of the frame table.
    logic [CFG_DATA_W-1:0] shadow_offset = OFFSET_BITS_RST;
    logic [CFG_DATA_W-1:0] shadow_frames = FRAMES_IN_USE_RST;
    logic                  shadow_policy = POLICY_FIFO;

    logic [30:0]  frame_page  [FRAMES];
    logic         frame_used  [FRAMES];
    logic         frame_dirty [FRAMES];
    logic [15:0]  use_count   [FRAMES];
    int unsigned  fifo_ptr = 0;
    logic [31:0]  fault_count = '0;
    logic [31:0]  swap_count = '0;

    access_t pending_access[$];
    xlat_t   expected_xlat[$];

    logic idle_on = 1'b1;
    logic hold_start = 1'b0;
    int   hold_left = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   fail_count = 0;
    int   checked = 0;
    int   hits_seen = 0;
    int   swaps_seen = 0;
    int   settings_run = 0;

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            frame_used[i] = 1'b0;
            frame_dirty[i] = 1'b0;
            use_count[i] = '0;
        end
    end

    function automatic int unsigned eff_offset();
        if (shadow_offset < OFFSET_BITS_MIN)
            return 32'(OFFSET_BITS_MIN);
        if (shadow_offset > OFFSET_BITS_MAX)
            return 32'(OFFSET_BITS_MAX);
        return 32'(shadow_offset);
    endfunction

    function automatic int unsigned eff_frames();
        if (shadow_frames < 5'd1)
            return 1;
        if (32'(shadow_frames) > FRAMES)
            return FRAMES;
        return 32'(shadow_frames);
    endfunction

    // Translates one reference and updates the shadow frame table.
    function automatic xlat_t translate_page(input logic [31:0] laddr, input logic wr);
        xlat_t       r;
        int unsigned ob;
        int unsigned n;
        int unsigned fr;
        logic [30:0] page;
        logic [31:0] offs;
        logic        found;
        logic        free_found;
        ob = eff_offset();
        n = eff_frames();
        page = 31'(laddr >> ob);
        offs = laddr & ((32'd1 << ob) - 32'd1);
        found = 1'b0;
        free_found = 1'b0;
        fr = 0;
        r.dirty_evicted = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && frame_used[i] && frame_page[i] == page) begin
                fr = i;
                found = 1'b1;
            end
        end
        if (found) begin
            if (use_count[fr] != '1)
                use_count[fr]++;
            if (wr)
                frame_dirty[fr] = 1'b1;
        end else begin
            fault_count++;
            for (int i = 0; i < n; i++) begin
                if (!free_found && !frame_used[i]) begin
                    fr = i;
                    free_found = 1'b1;
                end
            end
            if (!free_found) begin
                if (shadow_policy == POLICY_FIFO) begin
                    // A pointer left beyond a lowered frame count restarts at frame 0.
                    fr = (fifo_ptr < n) ? fifo_ptr : 0;
                    fifo_ptr = (fr + 1) % n;
                end else begin
                    fr = 0;
                    for (int i = 1; i < n; i++)
                        if (use_count[i] < use_count[fr])
                            fr = i;
                end
                if (frame_dirty[fr]) begin
                    r.dirty_evicted = 1'b1;
                    swap_count++;
                end
            end
            frame_used[fr] = 1'b1;
            frame_page[fr] = page;
            use_count[fr] = 16'd1;
            frame_dirty[fr] = wr;
        end
        r.phys_addr = (32'(fr) << ob) | offs;
        r.hit = found;
        r.fault_total = fault_count;
        r.swap_out_total = swap_count;
        return r;
    endfunction

    // Source side: offers pending items and predicts each accepted one.
    always @(posedge aclk) begin : drive_src
        access_t acc;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_xlat.push_back(translate_page(s_tdata, s_tuser[0]));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_access.size() > 0) begin
                    acc = pending_access.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= acc.addr;
                    s_tuser <= acc.wr;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long sink hold-off, counted apart from the short random stalls.
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sink side: checks every accepted result item against the oldest prediction.
    always @(posedge aclk) begin : watch_result
        xlat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_xlat.size() == 0) begin
                    $error("result item with no translation pending: %0h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_xlat.pop_front();
                    check_field("physical_address", want.phys_addr, m_tdata[31:0]);
                    check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
                    check_field("dirty_evicted", 32'(want.dirty_evicted),
                                32'(m_tuser[1]));
                    check_field("fault_total", want.fault_total, m_tdata[63:32]);
                    check_field("swap_out_total", want.swap_out_total, m_tdata[95:64]);
                    checked++;
                    hits_seen += int'(want.hit);
                    swaps_seen += int'(want.dirty_evicted);
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [31:0] addr, input logic wr);
        access_t acc;
        acc.addr = addr;
        acc.wr = wr;
        pending_access.push_back(acc);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_OFFSET_BITS:   shadow_offset = val;
            REG_FRAMES_IN_USE: shadow_frames = val;
            REG_POLICY:        shadow_policy = val[0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] ob,
                              input logic [CFG_DATA_W-1:0] fr,
                              input logic [CFG_DATA_W-1:0] pol);
        @(posedge aclk);
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_FRAMES_IN_USE, fr);
        write_reg(REG_POLICY, pol);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_run++;
    endtask

    // Sender pause: wait until every offered item has its result back.
    task automatic drain();
        while (pending_access.size() != 0 || s_tvalid || expected_xlat.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly pages from a small working set so that hits and evictions mix.
    task automatic random_phase(input int count);
        logic [31:0] pool [24];
        int          pool_n;
        int unsigned ob;
        logic [31:0] page;
        logic [31:0] offs;
        logic [31:0] addr;
        ob = eff_offset();
        pool_n = eff_frames() + $urandom_range(0, 6);
        for (int k = 0; k < 24; k++)
            pool[k] = $urandom();
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                addr = $urandom();
            end else begin
                page = pool[$urandom_range(0, pool_n - 1)];
                offs = $urandom() & ((32'd1 << ob) - 32'd1);
                addr = (page << ob) | offs;
            end
            push_item(addr, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: fill every frame, then FIFO evictions of dirty frames.
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'h0000_0FFF, 1'b1);
        push_item(32'hFFFF_F000, 1'b0);
        for (int p = 1; p <= 14; p++)
            push_item((32'(p) << 12) | 32'(p), p[0]);
        push_item(32'h0004_0000, 1'b0);
        push_item(32'h0004_1000, 1'b1);
        drain();

        // The FIFO pointer now sits at the lowered frame count.
        set_config(5'd12, 5'd2, {4'b0, POLICY_FIFO});
        push_item(32'h0004_2000, 1'b0);
        drain();

        // Raising the count again brings back the frames that were left alone.
        set_config(5'd12, 5'd31, {4'b0, POLICY_FIFO});
        push_item(32'h0000_A123, 1'b0);
        drain();

        // Zero offset width and zero frames clamp to one; only bit 0 selects policy.
        set_config(5'd0, 5'd0, 5'b11111);
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'hFFFF_FFFE, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        drain();

        set_config(5'd31, 5'd16, {4'b0, POLICY_LFU});
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h000F_FFFF, 1'b1);
        push_item(32'h0000_0000, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph != 3 && ph != 7);
            case (ph)
                0: set_config(5'd1, 5'd16, {4'b0, POLICY_FIFO});
                1: set_config(5'd20, 5'd16, {4'b0, POLICY_LFU});
                2: set_config(5'($urandom_range(1, 20)), 5'($urandom_range(1, 16)),
                              {4'b0, POLICY_FIFO});
                4: set_config(5'd7, 5'd3, {4'b0, POLICY_LFU});
                6: set_config(5'($urandom_range(0, 31)), 5'd1,
                              5'($urandom_range(0, 31)));
                default: set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                    5'($urandom_range(0, 31)));
            endcase
            random_phase(90);
            if (ph == 2) begin
                // The sink holds off while the source keeps offering items.
                @(posedge aclk);
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Checked %0d translations under %0d register settings.", checked,
                 settings_run);
        $display("Saw %0d hits, %0d faults and %0d dirty swap-outs.", hits_seen,
                 checked - hits_seen, swaps_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
